@@ hw/rtl/rfmd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reservoir sequencer package
// Shared types and constants: configuration block, item payloads, codes.
// ----------------------------------------------------------------------------
package rfmd_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_FILL_TIMEOUT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIX_WAIT     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DISPENSE     = 2'd2;

  // Configuration reset values
  localparam logic [31:0] FILL_TIMEOUT_RST = 32'd30000;
  localparam logic [31:0] MIX_WAIT_RST     = 32'd4000;
  localparam logic [31:0] DISPENSE_RST     = 32'd10000;

  // Request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WATER = 2'd1;
  localparam logic [1:0] REQ_FERT  = 2'd2;

  // Reported phase codes
  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_FILL_WATER = 3'd1;
  localparam logic [2:0] PH_FILL_MIX   = 3'd2;
  localparam logic [2:0] PH_MIX_WAIT   = 3'd3;
  localparam logic [2:0] PH_DISPENSE   = 3'd4;

  typedef struct packed {
    logic [31:0] fill_timeout_ms;
    logic [31:0] mix_wait_ms;
    logic [31:0] dispense_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_ms;
    logic        level_full;
  } req_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       water_valve_open;
    logic       fert_valve_open;
    logic       outlet_valve_open;
    logic       available;
  } res_t;

endpackage

@@ hw/rtl/rfmd_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reservoir sequencer configuration registers
// Three 32-bit timing limits, written through a plain write port.
// ----------------------------------------------------------------------------
module rfmd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rfmd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]                   cfg_wdata_i,
  output rfmd_pkg::cfg_t                cfg_o
);
  import rfmd_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode write; unknown index leaves everything alone
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FILL_TIMEOUT: cfg_d.fill_timeout_ms = cfg_wdata_i;
        CFG_MIX_WAIT:     cfg_d.mix_wait_ms     = cfg_wdata_i;
        CFG_DISPENSE:     cfg_d.dispense_ms     = cfg_wdata_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fill_timeout_ms <= FILL_TIMEOUT_RST;
      cfg_q.mix_wait_ms     <= MIX_WAIT_RST;
      cfg_q.dispense_ms     <= DISPENSE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/rfmd_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reservoir sequencer core
// Phase state machine, pending requests and valve state; updates once per
// transaction and presents the post-update status.
// ----------------------------------------------------------------------------
module rfmd_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  rfmd_pkg::req_t req_i,
  input  rfmd_pkg::cfg_t cfg_i,
  output rfmd_pkg::res_t res_o
);
  import rfmd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE       = 5'b00001,
    ST_FILL_WATER = 5'b00010,
    ST_FILL_MIX   = 5'b00100,
    ST_MIX_WAIT   = 5'b01000,
    ST_DISPENSE   = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] start_q, start_d;
  logic        water_pend_q, water_pend_d;
  logic        fert_pend_q, fert_pend_d;
  logic        water_open_q, water_open_d;
  logic        fert_open_q, fert_open_d;
  logic        outlet_open_q, outlet_open_d;

  logic [31:0] elapsed;
  logic [31:0] limit;
  logic        expired;

  // One modular subtract and one compare against the limit of this phase
  assign elapsed = req_i.now_ms - start_q;

  always_comb begin
    unique case (state_q)
      ST_FILL_WATER, ST_FILL_MIX: limit = cfg_i.fill_timeout_ms;
      ST_MIX_WAIT:                limit = cfg_i.mix_wait_ms;
      default:                    limit = cfg_i.dispense_ms;
    endcase
  end

  assign expired = elapsed > limit;

  // Next-state logic
  always_comb begin
    state_d       = state_q;
    start_d       = start_q;
    water_pend_d  = water_pend_q;
    fert_pend_d   = fert_pend_q;
    water_open_d  = water_open_q;
    fert_open_d   = fert_open_q;
    outlet_open_d = outlet_open_q;
    if (step_i) begin
      unique case (req_i.req_type)
        REQ_TICK: begin
          unique case (state_q)
            ST_IDLE: begin
              if (fert_pend_q) begin
                fert_pend_d  = 1'b0;
                water_pend_d = 1'b0;
                water_open_d = 1'b1;
                fert_open_d  = 1'b1;
                state_d      = ST_FILL_MIX;
                start_d      = req_i.now_ms;
              end else if (water_pend_q) begin
                water_pend_d = 1'b0;
                water_open_d = 1'b1;
                state_d      = ST_FILL_WATER;
                start_d      = req_i.now_ms;
              end
            end
            ST_FILL_WATER: begin
              if (req_i.level_full || expired) begin
                water_open_d = 1'b0;
                state_d      = ST_DISPENSE;
                start_d      = req_i.now_ms;
              end
            end
            ST_FILL_MIX: begin
              if (req_i.level_full || expired) begin
                water_open_d = 1'b0;
                fert_open_d  = 1'b0;
                state_d      = ST_MIX_WAIT;
                start_d      = req_i.now_ms;
              end
            end
            ST_MIX_WAIT: begin
              if (expired) begin
                state_d = ST_DISPENSE;
                start_d = req_i.now_ms;
              end
            end
            ST_DISPENSE: begin
              // outlet waits while either inlet is still open
              if (!water_open_q && !fert_open_q) begin
                if (!outlet_open_q) begin
                  outlet_open_d = 1'b1;
                  start_d       = req_i.now_ms;
                end else if (expired) begin
                  outlet_open_d = 1'b0;
                  state_d       = ST_IDLE;
                  start_d       = req_i.now_ms;
                end
              end
            end
            default: begin
              state_d = ST_IDLE;
              start_d = req_i.now_ms;
            end
          endcase
        end
        REQ_WATER: if (state_q == ST_IDLE) water_pend_d = 1'b1;
        REQ_FERT:  if (state_q == ST_IDLE) fert_pend_d  = 1'b1;
        default:   ; // unused request code
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      start_q       <= '0;
      water_pend_q  <= 1'b0;
      fert_pend_q   <= 1'b0;
      water_open_q  <= 1'b0;
      fert_open_q   <= 1'b0;
      outlet_open_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      start_q       <= start_d;
      water_pend_q  <= water_pend_d;
      fert_pend_q   <= fert_pend_d;
      water_open_q  <= water_open_d;
      fert_open_q   <= fert_open_d;
      outlet_open_q <= outlet_open_d;
    end
  end

  // Status after this transaction
  always_comb begin
    unique case (state_d)
      ST_FILL_WATER: res_o.phase = PH_FILL_WATER;
      ST_FILL_MIX:   res_o.phase = PH_FILL_MIX;
      ST_MIX_WAIT:   res_o.phase = PH_MIX_WAIT;
      ST_DISPENSE:   res_o.phase = PH_DISPENSE;
      default:       res_o.phase = PH_IDLE;
    endcase
    res_o.water_valve_open  = water_open_d;
    res_o.fert_valve_open   = fert_open_d;
    res_o.outlet_valve_open = outlet_open_d;
    res_o.available         = (state_d == ST_IDLE);
  end

endmodule

@@ hw/rtl/reservoir_fill_mix_dispense_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reservoir fill / mix / dispense sequencer
// Drives the water inlet, fertilizer inlet and outlet valves of a watering
// reservoir from requests and timestamped update ticks.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_ready    rfmd_pkg::req_t
//   out      output     out_valid/out_ready  rfmd_pkg::res_t
//   cfg      input      cfg_we               cfg_idx, cfg_wdata (32 bits)
//
// One status transaction per request transaction, through the input
// register, then the state update and result register.
// A new request is taken every cycle while the result side keeps up.
// Reset restores the default timing limits and the idle phase.
// A stalled result holds both stages; the input register refills as soon as
// its contents move on.
// ----------------------------------------------------------------------------
module reservoir_fill_mix_dispense_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rfmd_pkg::req_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rfmd_pkg::res_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [rfmd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]                   cfg_wdata_i
);
  import rfmd_pkg::*;

  cfg_t cfg;
  req_t in_data_q;
  logic in_valid_q;
  res_t out_data_q;
  logic out_valid_q;
  res_t res;
  logic advance;
  logic step;

  rfmd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Pipeline flow control
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  rfmd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (in_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
